[src/mrc_pkg.sv]
// Shared types and constants of the Muskingum reservoir cascade.
package mrc_pkg;

    // Field and register widths.
    localparam int K_W         = 32;
    localparam int X_W         = 16;
    localparam int DT_W        = 16;
    localparam int RAIN_W      = 31;
    localparam int FLOW_W      = 32;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    // Fixed-point formats. Q.32 terms stay below 2^50, so DEN_W has a spare bit.
    localparam int FRAC_W      = 16;
    localparam int Q32_FRAC_W  = 32;
    localparam int DEN_W       = 51;
    localparam int REM_W       = DEN_W + 1;
    localparam int QUOT_W      = 17;
    localparam int COEF_W      = QUOT_W + 1;
    localparam int MUL_A_W     = K_W + 1;
    localparam int PROD_W      = MUL_A_W + COEF_W;
    localparam int ACC_W       = PROD_W + 1;

    // Divider sequencing: one integer bit and sixteen fraction bits.
    localparam int DIV_STEPS   = QUOT_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam int DEF_NUM_RESERVOIRS = 8;

    localparam logic [K_W-1:0]           K_RESET    = 32'd65536;
    localparam logic [X_W-1:0]           X_RESET    = 16'd0;
    localparam logic [X_W-1:0]           X_MAX      = 16'd32768;
    localparam logic [QUOT_W-1:0]        ONE_Q16    = 17'd65536;
    localparam logic signed [FLOW_W-1:0] FLOW_RESET = 32'sd66;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_STORAGE_CONSTANT,
        REG_WEIGHTING_FACTOR
    } cfg_reg_t;

    typedef enum logic [1:0] {
        COEF_C0,
        COEF_C1,
        COEF_C2
    } coef_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_LAT_B,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_RES_P0,
        ST_RES_P1,
        ST_RES_P2,
        ST_RES_P3,
        ST_RES_WB,
        ST_EMIT
    } state_t;

    // Commands for the shared multiply-accumulate unit.
    typedef struct packed {
        logic signed [MUL_A_W-1:0] mul_a;
        logic signed [COEF_W-1:0]  mul_b;
        logic                      acc_load;
        logic                      acc_add;
    } mac_ctrl_t;

    // Start request for the shared divider.
    typedef struct packed {
        logic             start;
        logic [DEN_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

endpackage

[src/muskingum_reservoir_cascade_core.sv]
// Top level of the Muskingum reservoir cascade: sequencer, flow memory and shared units.
//
// Use of the block:
// Each input transfer on the in channel (in_valid high, in_stall low) is one routing
// time step: step_length, rain_start, rain_end and emit_output. The block then derives
// the three Muskingum coefficients with one shared restoring divider and routes the
// step through NUM_RESERVOIRS reservoirs with one shared multiply-accumulate unit.
// When emit_output was set, one transfer on the out channel carries outlet_flow,
// the outflow of the last reservoir clamped at zero; otherwise the step gives nothing.
// Sequence: after the accepting edge in_stall stays high until the block is back in
// ST_IDLE, so no new step is taken before the last one is through. The setup states
// ST_MUL_A, ST_MUL_B and ST_LAT_B form 2K(1-X) and 2KX on the multiplier, each
// coefficient is one divider run (start, 17 divider steps, done), and each reservoir
// passes through ST_RES_P0 to ST_RES_P3 and ST_RES_WB on the multiply-accumulate unit
// and the flow memory; an emitting step then passes through ST_EMIT. With K and dt
// both zero the divider is skipped. The result sits in an output register; the next
// item is taken while it waits. If the receiver still stalls when the next result is
// ready, the block holds there. Configuration writes (cfg_ready is always high)
// must go in while the block is idle; the block itself does not enforce this.
// Reset sets K to one time unit, X to zero and every reservoir flow to 66 (about
// 0.001); the flows come back through per-entry valid bits, so no clearing pass runs.
module muskingum_reservoir_cascade_core
#(
    parameter int NUM_RESERVOIRS = mrc_pkg::DEF_NUM_RESERVOIRS
)
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [mrc_pkg::DT_W-1:0]            step_length,
    input  logic [mrc_pkg::RAIN_W-1:0]          rain_start,
    input  logic [mrc_pkg::RAIN_W-1:0]          rain_end,
    input  logic                                emit_output,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [mrc_pkg::RAIN_W-1:0]          outlet_flow,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mrc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mrc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int IDX_W = $clog2(NUM_RESERVOIRS);
    localparam int SHIFT_W = mrc_pkg::ACC_W - mrc_pkg::FRAC_W;
    localparam int HI_W = SHIFT_W - mrc_pkg::FLOW_W + 1;

    // Sequencer and control state.
    mrc_pkg::state_t                    state_reg;
    mrc_pkg::state_t                    state_next;
    mrc_pkg::coef_sel_t                 coef_idx_reg;
    logic [IDX_W-1:0]                   res_idx_reg;
    logic [NUM_RESERVOIRS-1:0]          valid_reg;
    logic                               rd_valid_reg;
    logic                               out_valid_reg;
    logic [mrc_pkg::K_W-1:0]            k_reg;
    logic [mrc_pkg::X_W-1:0]            x_reg;

    // Datapath registers.
    logic [mrc_pkg::DT_W-1:0]           dt_reg;
    logic                               emit_reg;
    logic signed [mrc_pkg::FLOW_W-1:0]  prev_new_reg;
    logic signed [mrc_pkg::FLOW_W-1:0]  prev_old_reg;
    logic [mrc_pkg::DEN_W-1:0]          a_reg;
    logic [mrc_pkg::DEN_W-1:0]          b_reg;
    logic                               coef_neg_reg;
    logic signed [mrc_pkg::COEF_W-1:0]  c0_reg;
    logic signed [mrc_pkg::COEF_W-1:0]  c1_reg;
    logic signed [mrc_pkg::COEF_W-1:0]  c2_reg;
    logic signed [mrc_pkg::FLOW_W-1:0]  rd_data_reg;
    logic [mrc_pkg::RAIN_W-1:0]         outlet_flow_reg;

    // Flow memory, one entry per reservoir.
    logic signed [mrc_pkg::FLOW_W-1:0]  flow_mem [NUM_RESERVOIRS];

    // Combinational control.
    logic                               in_take;
    logic                               out_take;
    logic                               slot_free;
    logic                               last_res;
    logic                               den_zero;
    logic                               a_load;
    logic                               b_load;
    logic                               coef_direct;
    logic                               coef_load;
    logic                               mem_rd;
    logic                               mem_we;
    logic                               res_step;
    logic                               out_load;
    logic                               num_neg;
    logic [mrc_pkg::DEN_W-1:0]          num_pos;
    logic [mrc_pkg::DEN_W-1:0]          num_sub;
    logic [mrc_pkg::DEN_W-1:0]          dt_q32;
    logic [mrc_pkg::DEN_W-1:0]          den;
    logic [mrc_pkg::QUOT_W-1:0]         one_minus_x;
    logic signed [mrc_pkg::FLOW_W-1:0]  old_flow;
    logic signed [mrc_pkg::COEF_W-1:0]  coef_value;
    mrc_pkg::mac_ctrl_t                 mac_ctrl;
    mrc_pkg::div_req_t                  div_req;
    logic                               div_done;
    logic [mrc_pkg::QUOT_W-1:0]         div_quot;
    logic signed [mrc_pkg::PROD_W-1:0]  mac_prod;
    logic signed [mrc_pkg::ACC_W-1:0]   mac_acc;

    // Reservoir result: truncate toward zero, saturate, clamp.
    logic signed [mrc_pkg::ACC_W-1:0]   acc_biased;
    logic signed [SHIFT_W-1:0]          acc_shift;
    logic [HI_W-1:0]                    acc_hi;
    logic signed [mrc_pkg::FLOW_W-1:0]  flow_sat;
    logic signed [mrc_pkg::FLOW_W-1:0]  flow_clamped;

    mrc_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quot)
    );

    mrc_mac u_mac
    (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .prod (mac_prod),
        .acc  (mac_acc)
    );

    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign outlet_flow = outlet_flow_reg;
    assign in_take     = in_valid && !in_stall;
    assign out_take    = out_valid_reg && !out_stall;
    assign slot_free   = !out_valid_reg || !out_stall;
    assign last_res    = (res_idx_reg == IDX_W'(NUM_RESERVOIRS - 1));

    // Q.32 terms: dt, the divisor, and the coefficient numerators.
    always_comb
    begin
        dt_q32      = mrc_pkg::DEN_W'({dt_reg, {mrc_pkg::Q32_FRAC_W{1'b0}}});
        den         = a_reg + dt_q32;
        den_zero    = (den == '0);
        one_minus_x = mrc_pkg::ONE_Q16 - {1'b0, x_reg};
        unique case (coef_idx_reg)
            mrc_pkg::COEF_C0:
            begin
                num_pos = dt_q32;
                num_sub = b_reg;
            end
            mrc_pkg::COEF_C1:
            begin
                num_pos = dt_q32 + b_reg;
                num_sub = '0;
            end
            default:
            begin
                num_pos = a_reg;
                num_sub = dt_q32;
            end
        endcase
        num_neg = (num_pos < num_sub);
    end

    // A reservoir that was never written reads as its reset flow.
    assign old_flow = rd_valid_reg ? rd_data_reg : mrc_pkg::FLOW_RESET;

    always_comb
    begin
        acc_biased = mac_acc + (mac_acc[mrc_pkg::ACC_W-1]
            ? {{SHIFT_W{1'b0}}, {mrc_pkg::FRAC_W{1'b1}}} : '0);
        acc_shift  = acc_biased[mrc_pkg::ACC_W-1:mrc_pkg::FRAC_W];
        acc_hi     = acc_shift[SHIFT_W-1:mrc_pkg::FLOW_W-1];
        if ((&acc_hi) || !(|acc_hi))
        begin
            flow_sat = acc_shift[mrc_pkg::FLOW_W-1:0];
        end
        else if (acc_shift[SHIFT_W-1])
        begin
            flow_sat = {1'b1, {(mrc_pkg::FLOW_W-1){1'b0}}};
        end
        else
        begin
            flow_sat = {1'b0, {(mrc_pkg::FLOW_W-1){1'b1}}};
        end
        flow_clamped = flow_sat[mrc_pkg::FLOW_W-1] ? '0 : flow_sat;
    end

    assign coef_value = coef_neg_reg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mrc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mrc_pkg::ST_MUL_A;
                end
            end
            mrc_pkg::ST_MUL_A:     state_next = mrc_pkg::ST_MUL_B;
            mrc_pkg::ST_MUL_B:     state_next = mrc_pkg::ST_LAT_B;
            mrc_pkg::ST_LAT_B:     state_next = mrc_pkg::ST_DIV_START;
            mrc_pkg::ST_DIV_START:
            begin
                state_next = den_zero ? mrc_pkg::ST_RES_P0 : mrc_pkg::ST_DIV_WAIT;
            end
            mrc_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = (coef_idx_reg == mrc_pkg::COEF_C2)
                        ? mrc_pkg::ST_RES_P0 : mrc_pkg::ST_DIV_START;
                end
            end
            mrc_pkg::ST_RES_P0:    state_next = mrc_pkg::ST_RES_P1;
            mrc_pkg::ST_RES_P1:    state_next = mrc_pkg::ST_RES_P2;
            mrc_pkg::ST_RES_P2:    state_next = mrc_pkg::ST_RES_P3;
            mrc_pkg::ST_RES_P3:    state_next = mrc_pkg::ST_RES_WB;
            mrc_pkg::ST_RES_WB:
            begin
                if (!last_res)
                begin
                    state_next = mrc_pkg::ST_RES_P0;
                end
                else
                begin
                    state_next = emit_reg ? mrc_pkg::ST_EMIT : mrc_pkg::ST_IDLE;
                end
            end
            mrc_pkg::ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = mrc_pkg::ST_IDLE;
                end
            end
            default:               state_next = mrc_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        in_stall         = 1'b1;
        a_load           = 1'b0;
        b_load           = 1'b0;
        coef_direct      = 1'b0;
        coef_load        = 1'b0;
        mem_rd           = 1'b0;
        mem_we           = 1'b0;
        res_step         = 1'b0;
        out_load         = 1'b0;
        mac_ctrl.mul_a   = {prev_new_reg[mrc_pkg::FLOW_W-1], prev_new_reg};
        mac_ctrl.mul_b   = c0_reg;
        mac_ctrl.acc_load = 1'b0;
        mac_ctrl.acc_add = 1'b0;
        div_req.start    = 1'b0;
        div_req.num      = num_neg ? (num_sub - num_pos) : (num_pos - num_sub);
        div_req.den      = den;
        unique case (state_reg)
            mrc_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            mrc_pkg::ST_MUL_A:
            begin
                mac_ctrl.mul_a = $signed({1'b0, k_reg});
                mac_ctrl.mul_b = $signed({1'b0, one_minus_x});
            end
            mrc_pkg::ST_MUL_B:
            begin
                mac_ctrl.mul_a = $signed({1'b0, k_reg});
                mac_ctrl.mul_b = $signed({2'b00, x_reg});
                a_load         = 1'b1;
            end
            mrc_pkg::ST_LAT_B:
            begin
                b_load = 1'b1;
            end
            mrc_pkg::ST_DIV_START:
            begin
                coef_direct   = den_zero;
                div_req.start = !den_zero;
            end
            mrc_pkg::ST_DIV_WAIT:
            begin
                coef_load = div_done;
            end
            mrc_pkg::ST_RES_P0:
            begin
                mem_rd = 1'b1;
            end
            mrc_pkg::ST_RES_P1:
            begin
                mac_ctrl.mul_a    = {prev_old_reg[mrc_pkg::FLOW_W-1], prev_old_reg};
                mac_ctrl.mul_b    = c1_reg;
                mac_ctrl.acc_load = 1'b1;
            end
            mrc_pkg::ST_RES_P2:
            begin
                mac_ctrl.mul_a   = {old_flow[mrc_pkg::FLOW_W-1], old_flow};
                mac_ctrl.mul_b   = c2_reg;
                mac_ctrl.acc_add = 1'b1;
            end
            mrc_pkg::ST_RES_P3:
            begin
                mac_ctrl.acc_add = 1'b1;
            end
            mrc_pkg::ST_RES_WB:
            begin
                mem_we   = 1'b1;
                res_step = 1'b1;
            end
            mrc_pkg::ST_EMIT:
            begin
                out_load = slot_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Control registers, configuration and valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mrc_pkg::ST_IDLE;
            coef_idx_reg  <= mrc_pkg::COEF_C0;
            res_idx_reg   <= '0;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            k_reg         <= mrc_pkg::K_RESET;
            x_reg         <= mrc_pkg::X_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (mrc_pkg::cfg_reg_t'(cfg_index))
                    mrc_pkg::REG_STORAGE_CONSTANT:
                    begin
                        k_reg <= cfg_data[mrc_pkg::K_W-1:0];
                    end
                    mrc_pkg::REG_WEIGHTING_FACTOR:
                    begin
                        x_reg <= (cfg_data[mrc_pkg::X_W-1:0] > mrc_pkg::X_MAX)
                            ? mrc_pkg::X_MAX : cfg_data[mrc_pkg::X_W-1:0];
                    end
                endcase
            end
            if (in_take)
            begin
                coef_idx_reg <= mrc_pkg::COEF_C0;
                res_idx_reg  <= '0;
            end
            if (coef_load && (coef_idx_reg != mrc_pkg::COEF_C2))
            begin
                coef_idx_reg <= mrc_pkg::coef_sel_t'(coef_idx_reg + 2'd1);
            end
            if (res_step)
            begin
                res_idx_reg <= last_res ? '0 : res_idx_reg + 1'b1;
            end
            if (mem_rd)
            begin
                rd_valid_reg <= valid_reg[res_idx_reg];
            end
            if (mem_we)
            begin
                valid_reg[res_idx_reg] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            dt_reg       <= step_length;
            emit_reg     <= emit_output;
            prev_new_reg <= $signed({1'b0, rain_end});
            prev_old_reg <= $signed({1'b0, rain_start});
        end
        if (a_load)
        begin
            a_reg <= {mac_prod[mrc_pkg::DEN_W-2:0], 1'b0};
        end
        if (b_load)
        begin
            b_reg <= {mac_prod[mrc_pkg::DEN_W-2:0], 1'b0};
        end
        if (div_req.start)
        begin
            coef_neg_reg <= num_neg;
        end
        if (coef_direct)
        begin
            c0_reg <= '0;
            c1_reg <= '0;
            c2_reg <= $signed({1'b0, mrc_pkg::ONE_Q16});
        end
        if (coef_load)
        begin
            unique case (coef_idx_reg)
                mrc_pkg::COEF_C0: c0_reg <= coef_value;
                mrc_pkg::COEF_C1: c1_reg <= coef_value;
                default:          c2_reg <= coef_value;
            endcase
        end
        if (res_step)
        begin
            prev_new_reg <= flow_sat;
            prev_old_reg <= old_flow;
        end
        if (out_load)
        begin
            outlet_flow_reg <= prev_new_reg[mrc_pkg::FLOW_W-1]
                ? '0 : prev_new_reg[mrc_pkg::RAIN_W-1:0];
        end
    end

    // Flow memory: one read and one write port, registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            flow_mem[res_idx_reg] <= flow_clamped;
        end
        if (mem_rd)
        begin
            rd_data_reg <= flow_mem[res_idx_reg];
        end
    end

    // The divider finishes only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == mrc_pkg::ST_DIV_WAIT))
        else $error("divider finished outside the coefficient wait state");

    // Coefficient magnitudes never exceed one.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (div_quot <= mrc_pkg::ONE_Q16))
        else $error("coefficient quotient above one");

    // Routing starts only after all three coefficients or the zero-divisor shortcut.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mrc_pkg::ST_RES_P0 && res_idx_reg == '0) |->
            (coef_idx_reg == mrc_pkg::COEF_C2 || den_zero))
        else $error("routing started before the coefficients were ready");

    // A result appears only from the emit state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == mrc_pkg::ST_EMIT))
        else $error("result raised outside the emit state");

endmodule

[src/mrc_divider.sv]
// Restoring fraction divider: floor(num * 2^16 / den) for num <= den, one bit a cycle.
module mrc_divider
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  mrc_pkg::div_req_t                req,
    output logic                             done,
    output logic [mrc_pkg::QUOT_W-1:0]       quotient
);

    logic                              running_reg;
    logic [mrc_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic                              done_reg;
    logic [mrc_pkg::REM_W-1:0]         rem_reg;
    logic [mrc_pkg::DEN_W-1:0]         den_reg;
    logic [mrc_pkg::QUOT_W-1:0]        quot_reg;

    logic [mrc_pkg::REM_W-1:0]         rem_shift;
    logic [mrc_pkg::REM_W-1:0]         den_ext;
    logic                              fits;
    logic                              last_step;

    // The first step takes the integer bit, so it does not shift.
    always_comb
    begin
        rem_shift = (cnt_reg == '0) ? rem_reg : {rem_reg[mrc_pkg::REM_W-2:0], 1'b0};
        den_ext   = {1'b0, den_reg};
        fits      = (rem_shift >= den_ext);
        last_step = (cnt_reg == mrc_pkg::DIV_CNT_W'(mrc_pkg::DIV_STEPS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            cnt_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else if (req.start)
        begin
            running_reg <= 1'b1;
            cnt_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= running_reg && last_step;
            if (running_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                begin
                    running_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= {1'b0, req.num};
            den_reg  <= req.den;
            quot_reg <= '0;
        end
        else if (running_reg)
        begin
            rem_reg  <= fits ? (rem_shift - den_ext) : rem_shift;
            quot_reg <= {quot_reg[mrc_pkg::QUOT_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

[src/mrc_mac.sv]
// Shared multiply-accumulate unit: a registered product feeding an accumulator.
module mrc_mac
(
    input  logic                                clk,
    input  mrc_pkg::mac_ctrl_t                  ctrl,
    output logic signed [mrc_pkg::PROD_W-1:0]   prod,
    output logic signed [mrc_pkg::ACC_W-1:0]    acc
);

    logic signed [mrc_pkg::PROD_W-1:0] prod_reg;
    logic signed [mrc_pkg::ACC_W-1:0]  acc_reg;
    logic signed [mrc_pkg::ACC_W-1:0]  prod_ext;

    assign prod_ext = mrc_pkg::ACC_W'(prod_reg);

    always_ff @(posedge clk)
    begin
        prod_reg <= mrc_pkg::PROD_W'(ctrl.mul_a * ctrl.mul_b);
        if (ctrl.acc_load)
        begin
            acc_reg <= prod_ext;
        end
        else if (ctrl.acc_add)
        begin
            acc_reg <= acc_reg + prod_ext;
        end
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the Muskingum reservoir cascade core.
module tb;
    import mrc_pkg::*;

    localparam int NUM_RES       = DEF_NUM_RESERVOIRS;
    // One routing step occupies the core for about this many cycles.
    localparam int STEP_CYCLES   = 61 + 5 * NUM_RES;
    localparam int SETTLE_CYCLES = 2 * STEP_CYCLES;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_STEPS   = 210;
    localparam int PRESSURE_HOLD = 600;
    localparam int BACKLOG_STEPS = 8;
    localparam int TIMEOUT_NS    = 2_000_000;

    localparam logic [RAIN_W-1:0] RAIN_MAX = '1;
    localparam longint FLOW_MAX = (64'sd1 <<< 31) - 64'sd1;
    localparam longint FLOW_MIN = -(64'sd1 <<< 31);

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [DT_W-1:0]          step_length;
    logic [RAIN_W-1:0]        rain_start;
    logic [RAIN_W-1:0]        rain_end;
    logic                     emit_output;
    logic                     out_valid;
    logic                     out_stall;
    logic [RAIN_W-1:0]        outlet_flow;
    logic                     cfg_valid;
    logic                     cfg_ready;
    cfg_reg_t                 cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    // Predicted register contents and reservoir flows.
    logic [K_W-1:0]           k_model;
    logic [X_W-1:0]           x_model;
    logic signed [FLOW_W-1:0] flow_model [NUM_RES];

    // Outlet flows still owed by the core, oldest first.
    logic [RAIN_W-1:0]        outlet_q [$];

    int                       mismatch_count;
    bit                       idle_on;
    int                       hold_req;

    muskingum_reservoir_cascade_core #(
        .NUM_RESERVOIRS(NUM_RES)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .step_length (step_length),
        .rain_start  (rain_start),
        .rain_end    (rain_end),
        .emit_output (emit_output),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .outlet_flow (outlet_flow),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("Regression FAIL");
        $finish;
    end

    // Restoring division: floor(num * 2^16 / den), with num never above den.
    function automatic longint frac_q16(longint unsigned num, longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        int i;
        quo = num / den;
        rem = num % den;
        for (i = 0; i < FRAC_W; i++)
        begin
            quo = quo << 1;
            rem = rem << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
        end
        return longint'(quo);
    endfunction

    // Signed coefficient (pos - neg) / den, sign and magnitude handled apart.
    function automatic longint coef_q16(longint unsigned pos, longint unsigned neg,
                                        longint unsigned den);
        if (pos >= neg)
            return frac_q16(pos - neg, den);
        return -frac_q16(neg - pos, den);
    endfunction

    // Weighted sum of three flows, truncated toward zero and saturated to 32 bits.
    function automatic logic signed [FLOW_W-1:0] blend_q16(longint c0, longint p,
                                                           longint c1, longint q,
                                                           longint c2, longint r);
        longint acc;
        longint v;
        acc = c0 * p + c1 * q + c2 * r;
        if (acc < 0)
            v = -((-acc) >>> FRAC_W);
        else
            v = acc >>> FRAC_W;
        if (v > FLOW_MAX)
            v = FLOW_MAX;
        if (v < FLOW_MIN)
            v = FLOW_MIN;
        return v[FLOW_W-1:0];
    endfunction

    // Routes one accepted time step through the predicted cascade.
    function automatic void route_step(logic [DT_W-1:0] dt, logic [RAIN_W-1:0] rs,
                                       logic [RAIN_W-1:0] re, logic emit);
        longint unsigned dt_q;
        longint unsigned a_q;
        longint unsigned b_q;
        longint unsigned den;
        longint c0;
        longint c1;
        longint c2;
        logic signed [FLOW_W-1:0] fresh [NUM_RES];
        int i;
        dt_q = 64'(dt) << Q32_FRAC_W;
        a_q  = 2 * 64'(k_model) * (64'(ONE_Q16) - 64'(x_model));
        b_q  = 2 * 64'(k_model) * 64'(x_model);
        den  = a_q + dt_q;
        if (den == 0)
        begin
            // No storage and no time: every reservoir keeps its flow.
            c0 = 0;
            c1 = 0;
            c2 = longint'(ONE_Q16);
        end
        else
        begin
            c0 = coef_q16(dt_q, b_q, den);
            c1 = coef_q16(dt_q + b_q, 0, den);
            c2 = coef_q16(a_q, dt_q, den);
        end
        fresh[0] = blend_q16(c0, longint'(re), c1, longint'(rs),
                             c2, longint'(flow_model[0]));
        for (i = 1; i < NUM_RES; i++)
            fresh[i] = blend_q16(c0, longint'(fresh[i-1]), c1, longint'(flow_model[i-1]),
                                 c2, longint'(flow_model[i]));
        // The unclamped sums feed downstream; only the stored flows are clamped.
        for (i = 0; i < NUM_RES; i++)
            flow_model[i] = fresh[i][FLOW_W-1] ? '0 : fresh[i];
        if (emit)
            outlet_q.push_back(flow_model[NUM_RES-1][RAIN_W-1:0]);
    endfunction

    // Offers one time step and predicts it once the transfer happens.
    task automatic offer_step(input logic [DT_W-1:0] dt, input logic [RAIN_W-1:0] rs,
                              input logic [RAIN_W-1:0] re, input logic emit);
        int gap;
        gap = idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        step_length <= dt;
        rain_start  <= rs;
        rain_end    <= re;
        emit_output <= emit;
        do @(posedge clk); while (in_stall);
        route_step(dt, rs, re, emit);
    endtask

    // Waits for every owed result, then lets a silent step run out as well.
    task automatic settle_block();
        in_valid <= 1'b0;
        while (outlet_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes both registers back to back; only called while the core is idle.
    task automatic load_config(input logic [CFG_DATA_W-1:0] k_data,
                               input logic [CFG_DATA_W-1:0] x_data);
        cfg_valid <= 1'b1;
        cfg_index <= REG_STORAGE_CONSTANT;
        cfg_data  <= k_data;
        do @(posedge clk); while (!cfg_ready);
        k_model = k_data;
        cfg_index <= REG_WEIGHTING_FACTOR;
        cfg_data  <= x_data;
        do @(posedge clk); while (!cfg_ready);
        x_model = (x_data[X_W-1:0] > X_MAX) ? X_MAX : x_data[X_W-1:0];
        cfg_valid <= 1'b0;
    endtask

    // Reset flows and reset coefficients, field extremes and a silent step.
    task automatic test_reset_state();
        offer_step(16'd1, '0, '0, 1'b1);
        offer_step(16'd0, RAIN_MAX, RAIN_MAX, 1'b1);
        offer_step(16'hFFFF, RAIN_MAX, '0, 1'b1);
        offer_step(16'd1, '0, RAIN_MAX, 1'b0);
        offer_step(16'd2, 31'd12345, 31'd678, 1'b1);
        settle_block();
    endtask

    // Register extremes, including weighting writes above one half.
    task automatic test_weighting_limits();
        load_config(32'd1, 32'd32768);
        offer_step(16'd1, RAIN_MAX, RAIN_MAX, 1'b1);
        offer_step(16'hFFFF, '0, RAIN_MAX, 1'b1);
        settle_block();
        load_config(32'h0001_0000, 32'h0000_FFFF);
        offer_step(16'd3, 31'h0005_0000, 31'h0002_8000, 1'b1);
        offer_step(16'd1, RAIN_MAX, '0, 1'b1);
        settle_block();
        load_config(32'hFFFF_FFFF, 32'hFFFF_9C40);
        offer_step(16'd1, RAIN_MAX, RAIN_MAX, 1'b1);
        offer_step(16'h8000, 31'h4000_0000, 31'h3FFF_FFFF, 1'b1);
        settle_block();
        load_config(32'hFFFF_FFFF, 32'd0);
        offer_step(16'hFFFF, RAIN_MAX, RAIN_MAX, 1'b1);
        offer_step(16'd1, '0, '0, 1'b1);
        settle_block();
    endtask

    // Zero storage constant, with and without a zero step length.
    task automatic test_zero_divisor();
        load_config(32'd0, 32'd0);
        offer_step(16'd0, RAIN_MAX, RAIN_MAX, 1'b1);
        offer_step(16'd0, 31'd5, 31'd7, 1'b1);
        offer_step(16'd3, 31'h0001_0000, 31'h0003_0000, 1'b1);
        settle_block();
        load_config(32'd0, 32'd32768);
        offer_step(16'd0, 31'h0010_0000, '0, 1'b1);
        settle_block();
    endtask

    // The receiver holds off for a long stretch while steps keep coming, so the
    // output register fills and the core has to stall its input.
    task automatic test_backpressure();
        int n;
        load_config(32'h0004_0000, 32'h0000_2000);
        idle_on  = 1'b0;
        hold_req = PRESSURE_HOLD;
        for (n = 0; n < BACKLOG_STEPS; n++)
            offer_step(16'($urandom_range(1, 8)), 31'($urandom), 31'($urandom), 1'b1);
        settle_block();
    endtask

    // Random steps over several register settings; some phases run without idling.
    task automatic test_random_phases();
        int phase;
        int n;
        logic [CFG_DATA_W-1:0] k_data;
        logic [CFG_DATA_W-1:0] x_data;
        logic [DT_W-1:0]       dt;
        logic [RAIN_W-1:0]     rs;
        logic [RAIN_W-1:0]     re;
        logic                  emit;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            idle_on = (phase % 3) != 2;
            case ($urandom_range(0, 6))
                0:       k_data = 32'd1;
                1:       k_data = 32'hFFFF_FFFF;
                2:       k_data = $urandom;
                6:       k_data = 32'd0;
                default: k_data = 32'h0001_0000 * $urandom_range(1, 32);
            endcase
            case ($urandom_range(0, 4))
                0:       x_data = $urandom;
                1:       x_data = 32'd0;
                2:       x_data = 32'd32768;
                default: x_data = $urandom_range(0, 32768);
            endcase
            load_config(k_data, x_data);
            for (n = 0; n < PHASE_STEPS; n++)
            begin
                case ($urandom_range(0, 9))
                    0:       dt = 16'($urandom);
                    1:       dt = '0;
                    default: dt = 16'($urandom_range(1, 16));
                endcase
                rs   = ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                   : 31'($urandom_range(0, 32'h0040_0000));
                re   = ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                   : 31'($urandom_range(0, 32'h0040_0000));
                emit = $urandom_range(0, 2) != 0;
                offer_step(dt, rs, re, emit);
            end
            settle_block();
        end
    endtask

    // Receiver: in idling phases it holds each result for a random number of
    // cycles after it shows up; a pending long hold-off request takes priority.
    initial
    begin : outlet_drain
        int hold;
        out_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_req > 0)
            begin
                hold     = hold_req;
                hold_req = 0;
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            if (idle_on)
            begin
                hold = $urandom_range(0, 15);
                out_stall <= 1'b1;
                do @(posedge clk); while (!out_valid);
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin : outlet_check
        logic [RAIN_W-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (outlet_q.size() == 0)
            begin
                $display("%0t: outlet_flow transfer with none expected, actual %0d",
                         $time, outlet_flow);
                mismatch_count++;
            end
            else
            begin
                want = outlet_q.pop_front();
                if (outlet_flow !== want)
                begin
                    $display("%0t: outlet_flow mismatch, expected %0d, actual %0d",
                             $time, want, outlet_flow);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : run
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        step_length <= '0;
        rain_start  <= '0;
        rain_end    <= '0;
        emit_output <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= REG_STORAGE_CONSTANT;
        cfg_data    <= '0;
        idle_on        = 1'b1;
        hold_req       = 0;
        mismatch_count = 0;
        k_model        = K_RESET;
        x_model        = X_RESET;
        foreach (flow_model[i])
            flow_model[i] = FLOW_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_weighting_limits();
        test_zero_divisor();
        test_backpressure();
        test_random_phases();

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[muskingum_reservoir_cascade_core.f]
src/mrc_pkg.sv
src/mrc_divider.sv
src/mrc_mac.sv
src/muskingum_reservoir_cascade_core.sv
tb/tb.sv
